[sv/tcrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrt_pkg
// Shared constants for the two-colour ratio temperature unit.
// ----------------------------------------------------------------------------
package tcrt_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [23:0] TEMP_MAX = 24'hFFFFFF;

  localparam int unsigned LOG_STEPS = 32;
  localparam int unsigned DIV_STEPS = 52;

  // Register indexes on the configuration port
  localparam logic [0:0] REG_SLOPE_B = 1'd0;
  localparam logic [0:0] REG_CALIB_K = 1'd1;

endpackage

[sv/tcrt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrt_in_if / tcrt_out_if
// Valid/ready channels for count pairs and temperature results.
// ----------------------------------------------------------------------------
interface tcrt_in_if #(parameter int COUNT_WIDTH = 20);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] red_count;
  logic [COUNT_WIDTH-1:0] green_count;
  modport source (output valid, red_count, green_count, input ready);
  modport sink   (input valid, red_count, green_count, output ready);
endinterface

interface tcrt_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] temperature;
  logic [1:0]  status;
  modport source (output valid, temperature, status, input ready);
  modport sink   (input valid, temperature, status, output ready);
endinterface

[sv/two_colour_ratio_temperature_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_colour_ratio_temperature_top
// Ratio pyrometer: T = B / ln(red / (green * K)) as a chain of cells.
//
//   channel   dir  handshake       payload
//   cin       in   valid/ready     red_count, green_count
//   cout      out  valid/ready     temperature, status
//   apb       in   psel/penable    slope_b (0x0), calib_k (0x4)
//
// The cell chain holds 32 log squaring cells, one ln cell and 52 divider cells,
// between the front and output registers. One item is accepted per cycle
// unless the output register is full and not taken, which stalls the whole
// chain. Reset (rst, synchronous) clears valids and slope_b; calib_k goes to 65536.
// ----------------------------------------------------------------------------
module two_colour_ratio_temperature_top #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  tcrt_in_if.sink                cin,
  tcrt_out_if.source             cout,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned NC = tcrt_pkg::LOG_STEPS + 1 + tcrt_pkg::DIV_STEPS;

  logic [31:0] slope_b, calib_k;
  logic        adv;
  logic        fv;

  logic        v   [NC+1];
  logic [1:0]  st  [NC+1];
  logic        fin [NC+1];
  logic [5:0]  pn  [NC+1];
  logic [5:0]  pd  [NC+1];
  logic [31:0] mn  [NC+1];
  logic [31:0] md  [NC+1];
  logic [31:0] fn  [NC+1];
  logic [31:0] fd  [NC+1];
  logic [51:0] num [NC+1];
  logic [63:0] rem [NC+1];
  logic [63:0] dv  [NC+1];

  // Configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      slope_b <= '0;
      calib_k <= 32'd65536;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        tcrt_pkg::REG_SLOPE_B: slope_b <= pwdata;
        tcrt_pkg::REG_CALIB_K: calib_k <= pwdata;
        default: ;
      endcase
    end
  end
  assign prdata = (paddr[2] == tcrt_pkg::REG_SLOPE_B) ? slope_b : calib_k;

  // Chain moves when the output register is free or being drained
  assign adv       = !cout.valid || cout.ready;
  assign cin.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) fv <= 1'b0;
    else if (adv) fv <= cin.valid;
  end

  tcrt_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk(clk), .adv(adv), .red(cin.red_count), .green(cin.green_count),
    .slope_b(slope_b), .calib_k(calib_k), .st(st[0]), .fin(fin[0]),
    .pn(pn[0]), .pd(pd[0]), .mn(mn[0]), .md(md[0]), .num(num[0])
  );
  assign v[0]   = fv;
  assign fn[0]  = '0;
  assign fd[0]  = '0;
  assign rem[0] = '0;
  assign dv[0]  = '0;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    tcrt_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst(rst), .adv(adv), .vin(v[g]),
      .st_in(st[g]), .fin_in(fin[g]), .pn_in(pn[g]), .pd_in(pd[g]),
      .mn_in(mn[g]), .md_in(md[g]), .fn_in(fn[g]), .fd_in(fd[g]),
      .num_in(num[g]), .rem_in(rem[g]), .div_in(dv[g]),
      .vout(v[g+1]), .st_out(st[g+1]), .fin_out(fin[g+1]),
      .pn_out(pn[g+1]), .pd_out(pd[g+1]), .mn_out(mn[g+1]), .md_out(md[g+1]),
      .fn_out(fn[g+1]), .fd_out(fd[g+1]), .num_out(num[g+1]),
      .rem_out(rem[g+1]), .div_out(dv[g+1])
    );
  end

  // Output register with saturation and status
  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (adv) begin
      cout.valid <= v[NC];
    end
    if (adv) begin
      priority if (fin[NC]) begin
        cout.status      <= st[NC];
        cout.temperature <= (st[NC] == tcrt_pkg::ST_SAT) ? tcrt_pkg::TEMP_MAX : '0;
      end else if (num[NC][51:24] != '0) begin
        cout.status      <= tcrt_pkg::ST_SAT;
        cout.temperature <= tcrt_pkg::TEMP_MAX;
      end else begin
        cout.status      <= tcrt_pkg::ST_OK;
        cout.temperature <= num[NC][23:0];
      end
    end
  end

endmodule

[sv/tcrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrt_cell
// One step of the chain. The first LOG_STEPS cells square the two log
// mantissas (one fraction bit each), the ln cell scales by ln 2, and the
// remaining cells each produce one restoring-division quotient bit.
// ----------------------------------------------------------------------------
module tcrt_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        vin,
  input  logic [1:0]  st_in,
  input  logic        fin_in,
  input  logic [5:0]  pn_in,
  input  logic [5:0]  pd_in,
  input  logic [31:0] mn_in,
  input  logic [31:0] md_in,
  input  logic [31:0] fn_in,
  input  logic [31:0] fd_in,
  input  logic [51:0] num_in,
  input  logic [63:0] rem_in,
  input  logic [63:0] div_in,
  output logic        vout,
  output logic [1:0]  st_out,
  output logic        fin_out,
  output logic [5:0]  pn_out,
  output logic [5:0]  pd_out,
  output logic [31:0] mn_out,
  output logic [31:0] md_out,
  output logic [31:0] fn_out,
  output logic [31:0] fd_out,
  output logic [51:0] num_out,
  output logic [63:0] rem_out,
  output logic [63:0] div_out
);

  localparam int unsigned LN_IDX = tcrt_pkg::LOG_STEPS;

  logic [1:0]  st_next;
  logic        fin_next;
  logic [31:0] mn_next, md_next, fn_next, fd_next;
  logic [51:0] num_next;
  logic [63:0] rem_next, div_next;
  logic [63:0] sqn, sqd;
  logic [63:0] lnum, lden, dd, lnv;
  logic [63:0] ph, pl;
  logic [64:0] trial;

  always_comb begin
    st_next  = st_in;
    fin_next = fin_in;
    mn_next  = mn_in;
    md_next  = md_in;
    fn_next  = fn_in;
    fd_next  = fd_in;
    num_next = num_in;
    rem_next = rem_in;
    div_next = div_in;
    sqn = '0; sqd = '0; lnum = '0; lden = '0; dd = '0; lnv = '0;
    ph = '0; pl = '0; trial = '0;
    if (IDX < LN_IDX) begin
      // Square both mantissas and take the next fraction bit
      sqn = (64'(mn_in) * 64'(mn_in)) >> 31;
      sqd = (64'(md_in) * 64'(md_in)) >> 31;
      fn_next = {fn_in[30:0], sqn[32]};
      fd_next = {fd_in[30:0], sqd[32]};
      mn_next = sqn[32] ? sqn[32:1] : sqn[31:0];
      md_next = sqd[32] ? sqd[32:1] : sqd[31:0];
    end else if (IDX == LN_IDX) begin
      // Difference of logs, times ln 2, and set up the divider
      lnum = {26'd0, pn_in, fn_in};
      lden = {26'd0, pd_in, fd_in};
      dd   = lnum - lden;
      ph   = 64'(dd[63:32]) * 64'(tcrt_pkg::LN2_Q32);
      pl   = 64'(dd[31:0]) * 64'(tcrt_pkg::LN2_Q32);
      lnv  = ph + {32'd0, pl[63:32]};
      div_next = lnv;
      rem_next = '0;
      if (!fin_in && (lnum <= lden || lnv == 64'd0)) begin
        st_next  = tcrt_pkg::ST_SAT;
        fin_next = 1'b1;
      end
    end else begin
      // One restoring quotient bit, numerator shifted in msb first
      trial = {rem_in, num_in[51]};
      if (trial >= {1'b0, div_in}) begin
        rem_next = 64'(trial - {1'b0, div_in});
        num_next = {num_in[50:0], 1'b1};
      end else begin
        rem_next = trial[63:0];
        num_next = {num_in[50:0], 1'b0};
      end
    end
  end

  // Hold the stage; advance whenever the chain moves
  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
    if (adv) begin
      st_out  <= st_next;
      fin_out <= fin_next;
      pn_out  <= pn_in;
      pd_out  <= pd_in;
      mn_out  <= mn_next;
      md_out  <= md_next;
      fn_out  <= fn_next;
      fd_out  <= fd_next;
      num_out <= num_next;
      rem_out <= rem_next;
      div_out <= div_next;
    end
  end

endmodule

[sv/tcrt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrt_front
// Screens the inputs, forms num and den and normalises both log mantissas.
// ----------------------------------------------------------------------------
module tcrt_front #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                   clk,
  input  logic                   adv,
  input  logic [COUNT_WIDTH-1:0] red,
  input  logic [COUNT_WIDTH-1:0] green,
  input  logic [31:0]            slope_b,
  input  logic [31:0]            calib_k,
  output logic [1:0]             st,
  output logic                   fin,
  output logic [5:0]             pn,
  output logic [5:0]             pd,
  output logic [31:0]            mn,
  output logic [31:0]            md,
  output logic [51:0]            num
);

  logic [63:0] nv, dv;
  logic [5:0]  pnv, pdv;
  logic        bad;

  function automatic logic [5:0] top_bit(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [31:0] norm(input logic [63:0] x, input logic [5:0] p);
    logic [31:0] m;
    if (p >= 6'd31) m = 32'(x >> (p - 6'd31));
    else m = 32'(x << (6'd31 - p));
    return m;
  endfunction

  always_comb begin
    nv  = 64'(red) << 16;
    dv  = 64'(green) * 64'(calib_k);
    pnv = top_bit(nv);
    pdv = top_bit(dv);
    bad = (red == '0) || (green == '0) || (calib_k == '0) || (nv <= dv);
  end

  // Register the normalised operands
  always_ff @(posedge clk) begin
    if (adv) begin
      st  <= bad ? tcrt_pkg::ST_INVALID : tcrt_pkg::ST_OK;
      fin <= bad;
      pn  <= pnv;
      pd  <= pdv;
      mn  <= norm(nv, pnv);
      md  <= norm(dv, pdv);
      num <= {slope_b, 20'd0};
    end
  end

endmodule
